// ----- hw/rtl/dfs_pkg.sv -----
package dfs_pkg;

    localparam int unsigned DEPTH_W  = 12;
    localparam int unsigned MIN_W    = 13;
    localparam int unsigned COUNT_W  = 20;
    localparam int unsigned SUM_W    = 31;
    localparam int unsigned MEAN_W   = 16;
    localparam int unsigned FRAC_W   = 4;
    // numerator of the mean: sum * 16 plus half the count
    localparam int unsigned NUM_W    = SUM_W + FRAC_W + 1;

    localparam int unsigned MAX_PIXELS_DEFAULT = 524288;

    localparam logic [MIN_W-1:0]   MIN_RESET = 13'd4096;
    localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};
    localparam logic [MEAN_W-1:0]  MEAN_MAX  = {MEAN_W{1'b1}};

    typedef struct packed {
        logic [DEPTH_W-1:0] depth;
        logic               frame_end;
    } pixel_t;

    typedef struct packed {
        logic [DEPTH_W-1:0] max_depth;
        logic [MIN_W-1:0]   min_nonzero_depth;
        logic [COUNT_W-1:0] nonzero_count;
        logic [MEAN_W-1:0]  mean_depth;
    } frame_stats_t;

    // running totals of the frame so far, current pixel included
    typedef struct packed {
        logic [DEPTH_W-1:0] max_depth;
        logic [MIN_W-1:0]   min_depth;
        logic [COUNT_W-1:0] count;
        logic [SUM_W-1:0]   sum;
    } running_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

// ----- hw/rtl/dfs_accum.sv -----
module dfs_accum #(
    parameter int unsigned MAX_PIXELS = dfs_pkg::MAX_PIXELS_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  dfs_pkg::pixel_t   pixel,
    output dfs_pkg::running_t totals
);
    import dfs_pkg::*;

    localparam longint unsigned COUNT_FIELD_MAX = (64'd1 << COUNT_W) - 64'd1;
    localparam longint unsigned LIMIT_FULL =
        (MAX_PIXELS > COUNT_FIELD_MAX) ? COUNT_FIELD_MAX : MAX_PIXELS;
    localparam logic [COUNT_W-1:0] COUNT_LIMIT = LIMIT_FULL[COUNT_W-1:0];

    running_t         run_reg;
    logic [SUM_W:0]   sum_wide;

    always_comb
    begin
        totals   = run_reg;
        sum_wide = {1'b0, run_reg.sum} + {{(SUM_W+1-DEPTH_W){1'b0}}, pixel.depth};
        if (pixel.depth > run_reg.max_depth)
        begin
            totals.max_depth = pixel.depth;
        end
        if (pixel.depth != '0)
        begin
            if ({1'b0, pixel.depth} < run_reg.min_depth)
            begin
                totals.min_depth = {1'b0, pixel.depth};
            end
            if (run_reg.count < COUNT_LIMIT)
            begin
                totals.count = run_reg.count + 1'b1;
            end
            // saturate the sum at its field maximum
            totals.sum = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg.max_depth <= '0;
            run_reg.min_depth <= MIN_RESET;
            run_reg.count     <= '0;
            run_reg.sum       <= '0;
        end
        else if (en)
        begin
            if (pixel.frame_end)
            begin
                // drop the totals, start the next frame afresh
                run_reg.max_depth <= '0;
                run_reg.min_depth <= MIN_RESET;
                run_reg.count     <= '0;
                run_reg.sum       <= '0;
            end
            else
            begin
                run_reg <= totals;
            end
        end
    end

endmodule

// ----- hw/rtl/dfs_div.sv -----
module dfs_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [dfs_pkg::SUM_W-1:0]     sum,
    input  logic [dfs_pkg::COUNT_W-1:0]   count,
    output dfs_pkg::div_status_t          status,
    output logic [dfs_pkg::MEAN_W-1:0]    mean
);
    import dfs_pkg::*;

    localparam int unsigned STEP_W = $clog2(NUM_W);

    logic [NUM_W-1:0]   num_reg;
    logic [COUNT_W:0]   rem_reg;
    logic [COUNT_W-1:0] div_reg;
    logic [STEP_W-1:0]  step_reg;
    logic               busy_reg;
    logic               done_reg;

    logic [COUNT_W:0]   rem_shift;
    logic               fits;
    logic [NUM_W-1:0]   num_start;

    assign num_start = {1'b0, sum, {FRAC_W{1'b0}}}
                     + {{(NUM_W-COUNT_W+1){1'b0}}, count[COUNT_W-1:1]};
    assign rem_shift = {rem_reg[COUNT_W-1:0], num_reg[NUM_W-1]};
    assign fits      = rem_shift >= {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(NUM_W - 1);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // one restoring step per cycle; quotient bits shift in behind the numerator
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num_start;
            rem_reg <= '0;
            div_reg <= count;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? (rem_shift - {1'b0, div_reg}) : rem_shift;
            num_reg <= {num_reg[NUM_W-2:0], fits};
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign mean = (|num_reg[NUM_W-1:MEAN_W]) ? MEAN_MAX : num_reg[MEAN_W-1:0];

endmodule

// ----- hw/rtl/depth_frame_statistics.sv -----
// Depth frame statistics.
// Pixels enter on the pixel channel (valid/ready), one transaction per pixel,
// with frame_end set on the last pixel of each frame. Ordinary pixels are
// taken at one per cycle while pixel_ready is high: the running maximum,
// nonzero minimum, nonzero count and nonzero sum update as each is taken.
// The last pixel of a frame closes the frame: its totals are captured and the
// running state cleared, then the mean (sum*16/count, rounded, 12.4 format)
// is worked out by a restoring divider, one quotient bit per cycle. The frame
// result then passes through the hold state and the output register to the
// stats channel; a frame with no nonzero pixel skips the divider.
// While the divider runs and until the result is in the output register,
// pixel_ready is low; after that the next frame's pixels flow again even if
// the result still waits to be taken.
// A stalled receiver holds the result in the output register; a further
// frame end then waits in the hold state until the register frees.
// Reset clears the running totals to their empty-frame values (maximum 0,
// minimum 4096, count and sum 0) and empties the output register.
module depth_frame_statistics #(
    parameter int unsigned MAX_PIXELS = dfs_pkg::MAX_PIXELS_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pixel_valid,
    output logic                  pixel_ready,
    input  dfs_pkg::pixel_t       pixel,
    output logic                  stats_valid,
    input  logic                  stats_ready,
    output dfs_pkg::frame_stats_t stats
);
    import dfs_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_HOLD
    } state_t;

    state_t             state_reg;
    logic               out_valid_reg;
    frame_stats_t       out_reg;
    frame_stats_t       hold_reg;

    logic               pixel_fire;
    logic               frame_fire;
    logic               div_start;
    logic               out_free;
    running_t           totals;
    div_status_t        div_status;
    logic [MEAN_W-1:0]  div_mean;

    assign pixel_ready = (state_reg == ST_IDLE);
    assign pixel_fire  = pixel_valid && pixel_ready;
    assign frame_fire  = pixel_fire && pixel.frame_end;
    assign div_start   = frame_fire && (totals.count != '0);
    assign out_free    = !out_valid_reg || stats_ready;

    dfs_accum #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_accum (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (pixel_fire),
        .pixel  (pixel),
        .totals (totals)
    );

    dfs_div u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .sum    (totals.sum),
        .count  (totals.count),
        .status (div_status),
        .mean   (div_mean)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // load a new result when the output register can take it,
            // otherwise drop the result once the receiver takes it
            if (state_reg == ST_HOLD && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && stats_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (frame_fire)
                    begin
                        state_reg <= (totals.count != '0) ? ST_DIVIDE : ST_HOLD;
                    end
                end
                ST_DIVIDE:
                begin
                    if (div_status.done)
                    begin
                        state_reg <= ST_HOLD;
                    end
                end
                ST_HOLD:
                begin
                    // advance only when the output register can take the result
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // payload registers: frame totals and the output register
    always_ff @(posedge clk)
    begin
        if (frame_fire)
        begin
            hold_reg.max_depth         <= totals.max_depth;
            hold_reg.min_nonzero_depth <= totals.min_depth;
            hold_reg.nonzero_count     <= totals.count;
            hold_reg.mean_depth        <= '0;
        end
        else if (state_reg == ST_DIVIDE && div_status.done)
        begin
            hold_reg.mean_depth <= div_mean;
        end
        if (state_reg == ST_HOLD && out_free)
        begin
            out_reg <= hold_reg;
        end
    end

    assign stats_valid = out_valid_reg;
    assign stats       = out_reg;

    // no pixel may be taken while the divider works on a frame
    assert property (@(posedge clk) disable iff (!rst_n)
        div_status.busy |-> !pixel_ready)
    else $error("pixel taken while divider busy");

    // an empty frame reports the reset minimum and a zero mean
    assert property (@(posedge clk) disable iff (!rst_n)
        (stats_valid && stats.nonzero_count == '0) |->
            (stats.min_nonzero_depth == MIN_RESET && stats.mean_depth == '0
             && stats.max_depth == '0))
    else $error("empty frame result inconsistent");

    // a frame with nonzero pixels has a minimum no larger than its maximum
    assert property (@(posedge clk) disable iff (!rst_n)
        (stats_valid && stats.nonzero_count != '0) |->
            (stats.min_nonzero_depth <= {1'b0, stats.max_depth}
             && stats.min_nonzero_depth != '0))
    else $error("nonzero frame min/max inconsistent");

    // a divider start, taken only from the idle state on a frame end, leads to the divide state with the divider busy
    assert property (@(posedge clk) disable iff (!rst_n)
        div_start |=> (state_reg == ST_DIVIDE && div_status.busy))
    else $error("divider start without divide state");

endmodule
